/* rtl/core/macp_pkg.sv */
// ----------------------------------------------------------------------------
// macp_pkg
// Shared types and constants of the address claim block.
// ----------------------------------------------------------------------------
package macp_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] now_ns;
        logic [31:0] addr_prefix;
        logic [15:0] addr_low;
        logic [15:0] addr_count;
        logic [30:0] random_offset;
        logic [15:0] random_fraction;
    } t_in_word;

    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_kind;
        logic [15:0] request_low;
        logic [15:0] req_count;
        logic [15:0] conflict_low;
        logic [15:0] conf_count;
        logic [1:0]  protocol_state;
        logic        save_request;
    } t_out_word;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_PROBE   = 2'd1;
    localparam logic [1:0] MODE_DEFEND  = 2'd2;
    localparam logic [1:0] MODE_RESERVE = 2'd3;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_PROBE    = 2'd1;
    localparam logic [1:0] ST_ANNOUNCE = 2'd2;

    localparam logic [1:0] KIND_PROBE    = 2'd0;
    localparam logic [1:0] KIND_DEFEND   = 2'd1;
    localparam logic [1:0] KIND_ANNOUNCE = 2'd2;

    localparam logic [2:0] CFG_PREFIX  = 3'd0;
    localparam logic [2:0] CFG_SIZE    = 3'd1;
    localparam logic [2:0] CFG_PINT    = 3'd2;
    localparam logic [2:0] CFG_PJIT    = 3'd3;
    localparam logic [2:0] CFG_AINT    = 3'd4;
    localparam logic [2:0] CFG_AJIT    = 3'd5;
    localparam logic [2:0] CFG_RETX    = 3'd6;

    localparam logic [15:0] DEFENSE_RANGE = 16'd8;
    localparam logic [19:0] NS_PER_MS     = 20'd1000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input word, compute overlap and decision
        logic div_start; // start offset remainder
        logic mul_start; // start delay computation
        logic commit;    // write state and build result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_claim;
        logic need_delay;
        logic div_done;
        logic mul_done;
    } t_stat;

endpackage

/* rtl/core/macp_ctrl.sv */
// ----------------------------------------------------------------------------
// macp_ctrl
// Sequencer that steps one word through decide, divide, delay and commit.
// ----------------------------------------------------------------------------
module macp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_out_full,
    input  macp_pkg::t_stat i_stat,
    output macp_pkg::t_cmd  o_cmd
);
    import macp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.need_claim) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_stat.need_delay) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                if (i_stat.mul_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/macp_dp.sv */
// ----------------------------------------------------------------------------
// macp_dp
// Claim state, overlap check, serial remainder and serial delay multiply.
// ----------------------------------------------------------------------------
module macp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  macp_pkg::t_in_word i_in,
    input  macp_pkg::t_cmd     i_cmd,
    output macp_pkg::t_stat    o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output macp_pkg::t_out_word o_res
);
    import macp_pkg::*;

    // Configuration.
    logic [31:0] r_prefix;
    logic [15:0] r_size, r_pint, r_pjit, r_aint, r_ajit;
    logic [3:0]  r_retx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 32'h91E0F000;
            r_size   <= 16'hFE00;
            r_pint   <= 16'd500;
            r_pjit   <= 16'd100;
            r_aint   <= 16'd3000;
            r_ajit   <= 16'd2000;
            r_retx   <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PREFIX: r_prefix <= i_cfg_data;
                CFG_SIZE:   r_size   <= i_cfg_data[15:0];
                CFG_PINT:   r_pint   <= i_cfg_data[15:0];
                CFG_PJIT:   r_pjit   <= i_cfg_data[15:0];
                CFG_AINT:   r_aint   <= i_cfg_data[15:0];
                CFG_AJIT:   r_ajit   <= i_cfg_data[15:0];
                CFG_RETX:   r_retx   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Claim state.
    logic [1:0]  r_cstate;
    logic [15:0] r_off, r_cnt;
    logic [3:0]  r_left;
    logic [63:0] r_deadline;

    // Captured word.
    t_in_word r_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
    end

    // Overlap against the current range (evaluated on the captured word).
    logic [15:0] ov_oe, ov_re, ov_n, ov_cs, ov_a, ov_b;
    logic        ov_hit;
    always_comb begin
        ov_oe = r_off + r_cnt;
        ov_re = r_in.addr_low + r_in.addr_count;
        ov_cs = '0;
        ov_a  = '0;
        ov_b  = '0;
        if (r_off >= r_in.addr_low && r_off <= ov_re) begin
            ov_cs = r_off;
            ov_a  = (ov_oe < ov_re) ? ov_oe : ov_re;
            ov_b  = r_off;
        end else if (r_in.addr_low >= r_off && r_in.addr_low <= ov_oe) begin
            ov_cs = r_in.addr_low;
            ov_a  = (ov_re < ov_oe) ? ov_re : ov_oe;
            ov_b  = r_in.addr_low;
        end
        ov_n   = (r_in.addr_prefix == r_prefix) ? (ov_a - ov_b) : 16'd0;
        ov_hit = (ov_n != 16'd0);
    end

    // Decision, registered in the decide cycle.
    logic [15:0] lim, clamp;
    logic        d_claim, d_delay, d_tick_go;
    logic [15:0] d_n;
    always_comb begin
        lim       = (r_size != 16'd0) ? (r_size - 16'd1) : 16'd0;
        clamp     = (r_in.addr_count > lim) ? lim : r_in.addr_count;
        d_claim   = 1'b0;
        d_n       = DEFENSE_RANGE;
        d_tick_go = (r_in.now_ns >= r_deadline) &&
                    (r_cstate == ST_PROBE || r_cstate == ST_ANNOUNCE);
        case (r_in.mode)
            MODE_PROBE:   d_claim = ov_hit && (r_cstate == ST_PROBE);
            MODE_DEFEND:  d_claim = ov_hit;
            MODE_RESERVE: begin
                d_claim = (clamp > r_cnt);
                d_n     = clamp;
            end
            default: d_claim = 1'b0;
        endcase
        d_delay = d_claim || ((r_in.mode == MODE_TICK) && d_tick_go);
    end

    logic        r_claim, r_tick_go, r_defend;
    logic [15:0] r_n, r_cs, r_ovn;
    logic [63:0] r_base;
    always_ff @(posedge i_clk) begin
        if (!i_cmd.load) begin
            r_claim   <= d_claim;
            r_tick_go <= (r_in.mode == MODE_TICK) && d_tick_go;
            r_defend  <= (r_in.mode == MODE_PROBE) && ov_hit && (r_cstate == ST_ANNOUNCE);
            r_n       <= d_n;
            r_cs      <= ov_cs;
            r_ovn     <= ov_n;
            r_base    <= (r_in.mode == MODE_RESERVE) ? 64'd0 : r_in.now_ns;
        end
    end
    // Decision values are stable from the decide cycle on, since the claim
    // state only changes at commit.
    assign o_stat.need_claim = d_claim;
    assign o_stat.need_delay = d_delay;

    // Serial remainder: random_offset mod (size - n), one bit per cycle.
    logic [15:0] r_div_d;
    logic [30:0] r_div_q;
    logic [15:0] r_rem;
    logic [4:0]  r_div_cnt;
    logic        r_div_busy, r_div_zero;
    logic [16:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem, r_div_q[30]};
    assign rem_sub = rem_sh - {1'b0, r_div_d};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= 5'd30;
            r_div_q    <= r_in.random_offset;
            r_rem      <= '0;
            r_div_d    <= r_size - d_n;
            r_div_zero <= !(r_size > d_n);
        end else if (r_div_busy) begin
            r_div_q <= {r_div_q[29:0], 1'b0};
            r_rem   <= (rem_sh >= {1'b0, r_div_d}) ? rem_sub[15:0] : rem_sh[15:0];
            if (r_div_cnt == 5'd0) r_div_busy <= 1'b0;
            else r_div_cnt <= r_div_cnt - 5'd1;
        end
    end
    assign o_stat.div_done = !r_div_busy && !i_cmd.div_start;

    // Serial delay: interval*1e6 + (jitter*frac*1e6)>>16, then saturating add.
    logic [31:0] r_jf;       // jitter * fraction
    logic [51:0] r_acc;      // jitter * fraction * 1e6
    logic [19:0] r_mbits;
    logic [4:0]  r_mcnt;
    logic [1:0]  r_mph;
    logic [15:0] r_int;
    logic [35:0] r_ins;
    logic        r_mbusy;
    logic        ann_sel;
    logic [15:0] sel_int, sel_jit;
    logic [64:0] sum;
    // The announce timing applies only to a tick that fires while announcing.
    assign ann_sel = (r_in.mode == MODE_TICK) && d_tick_go && (r_cstate == ST_ANNOUNCE);
    assign sel_int = ann_sel ? r_aint : r_pint;
    assign sel_jit = ann_sel ? r_ajit : r_pjit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
            r_mph   <= 2'd0;
            r_jf    <= 32'(sel_jit) * 32'(r_in.random_fraction);
            r_int   <= sel_int;
            r_acc   <= '0;
            r_mbits <= NS_PER_MS;
            r_mcnt  <= 5'd19;
        end else if (r_mbusy) begin
            unique case (r_mph)
                2'd0: begin
                    // Shift-add one multiplier bit per cycle.
                    r_acc   <= {r_acc[50:0], 1'b0} +
                               (r_mbits[19] ? {20'd0, r_jf} : 52'd0);
                    r_mbits <= {r_mbits[18:0], 1'b0};
                    if (r_mcnt == 5'd0) r_mph <= 2'd1;
                    else r_mcnt <= r_mcnt - 5'd1;
                end
                2'd1: begin
                    r_ins <= 36'(r_int) * 36'(NS_PER_MS);
                    r_mph <= 2'd2;
                end
                default: begin
                    r_mbusy <= 1'b0;
                end
            endcase
        end
    end
    assign o_stat.mul_done = !r_mbusy && !i_cmd.mul_start;
    assign sum = {1'b0, r_base} + {29'd0, r_ins} + {29'd0, r_acc[51:16]};

    // Commit.
    t_out_word n_res;
    always_comb begin
        n_res                = '0;
        n_res.protocol_state = r_cstate;
        if (r_claim) begin
            n_res.protocol_state = ST_PROBE;
        end else if (r_tick_go) begin
            n_res.send_valid = 1'b1;
            if (r_cstate == ST_PROBE) begin
                n_res.send_kind = KIND_PROBE;
                if (r_left <= 4'd1) begin
                    n_res.protocol_state = ST_ANNOUNCE;
                    n_res.save_request   = 1'b1;
                end
            end else begin
                n_res.send_kind = KIND_ANNOUNCE;
            end
        end else if (r_defend) begin
            n_res.send_valid   = 1'b1;
            n_res.send_kind    = KIND_DEFEND;
            n_res.conflict_low = r_cs;
            n_res.conf_count   = r_ovn;
        end
        n_res.request_low = r_claim ? (r_div_zero ? 16'd0 : r_rem) : r_off;
        n_res.req_count   = r_claim ? r_n : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstate   <= ST_IDLE;
            r_off      <= '0;
            r_cnt      <= '0;
            r_left     <= '0;
            r_deadline <= '0;
        end else if (i_cmd.commit) begin
            r_cstate <= n_res.protocol_state;
            r_off    <= n_res.request_low;
            r_cnt    <= n_res.req_count;
            if (r_claim) r_left <= r_retx;
            else if (r_tick_go && r_cstate == ST_PROBE)
                r_left <= (r_left <= 4'd1) ? 4'd0 : r_left - 4'd1;
            if (r_claim || r_tick_go)
                r_deadline <= sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) o_res <= n_res;
    end

endmodule

/* rtl/core/mac_address_claim_protocol.sv */
// ----------------------------------------------------------------------------
// mac_address_claim_protocol
// Multicast MAC address range claim engine with probe, announce and defend.
// ----------------------------------------------------------------------------
// Usage: each input word is an event (tick, received probe, received defend
// or announce, or reserve request). Every accepted word yields exactly one
// result word carrying the message to send, our range and the claim state.
// The input channel is i_in / i_in_valid / o_in_stall; the output channel is
// o_out / o_out_valid / i_out_stall. Registers are written through i_cfg_we /
// i_cfg_idx / i_cfg_data, and the user must do so only while the block is
// idle; the block itself does not enforce this. An event that makes no new
// claim and sets no deadline goes from decide straight to commit; a tick that
// sends first passes through the serial multiply of jitter by the nanosecond
// scale (one bit per cycle); a new claim also runs the serial remainder of the
// random offset before it. One word is worked on at a time; the next word can
// be accepted in the cycle after the previous one commits its result.
// Reset clears the claim to idle, with zero offset, count and deadline, and
// loads the registers with their default values.
// While the receiver stalls, a finished result waits in the output register;
// the next word may be accepted and worked on, and it waits to commit until
// the output register is free.
// ----------------------------------------------------------------------------
module mac_address_claim_protocol (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  macp_pkg::t_in_word   i_in,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output macp_pkg::t_out_word  o_out,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import macp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  r_out_valid;
    logic  out_full;

    // The output register is busy while a word waits and the receiver stalls.
    assign out_full = r_out_valid && i_out_stall;

    macp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_out_full (out_full),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    macp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_out_valid = r_out_valid;

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !out_full)
        else $error("result overwritten");

    // A word is accepted only when no other word is in flight.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall)
        else $error("second word accepted in flight");

    // Save is only reported together with a probe send.
    a_save_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.save_request) |->
        (o_out.send_valid && o_out.protocol_state == ST_ANNOUNCE))
        else $error("save without final probe");

endmodule
